// ===== hw/rtl/alx_pkg.sv =====
// ----------------------------------------------------------------------------
// Assembly line lexer package
// Shared constants, character classes and the result item type.
// ----------------------------------------------------------------------------
package alx_pkg;

  // Default line length and the width of the column fields of a result.
  localparam int LINE_LENGTH_DEF = 512;
  localparam int COL_OUT_W       = 9;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Lexer modes.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_NAME    = 3'd1;
  localparam logic [2:0] MODE_PREFIX  = 3'd2;
  localparam logic [2:0] MODE_MINUS   = 3'd3;
  localparam logic [2:0] MODE_DIGITS  = 3'd4;
  localparam logic [2:0] MODE_STRING  = 3'd5;
  localparam logic [2:0] MODE_STR_BS  = 3'd6;
  localparam logic [2:0] MODE_COMMENT = 3'd7;

  // Token kinds.
  localparam logic [3:0] KIND_BADINT = 4'd0;
  localparam logic [3:0] KIND_COLON  = 4'd1;
  localparam logic [3:0] KIND_COMMA  = 4'd2;
  localparam logic [3:0] KIND_NAME   = 4'd3;
  localparam logic [3:0] KIND_INT    = 4'd4;
  localparam logic [3:0] KIND_STRING = 4'd5;
  localparam logic [3:0] KIND_EOL    = 4'd6;
  localparam logic [3:0] KIND_STRAY  = 4'd7;
  localparam logic [3:0] KIND_UNTERM = 4'd8;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [3:0]           kind;
    logic [COL_OUT_W-1:0] start_col;
    logic [COL_OUT_W-1:0] end_col;
    logic                 is_hex;
    logic [7:0]           stray_char;
    logic                 last;
  } res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    is_hex_letter = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ===== hw/rtl/alx_step.sv =====
// ----------------------------------------------------------------------------
// Lexer step
// Holds the lexer state and turns one character into up to two results.
// ----------------------------------------------------------------------------
module alx_step #(
  parameter int LINE_LENGTH = alx_pkg::LINE_LENGTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    ch,
  output alx_pkg::res_t res0,
  output alx_pkg::res_t res1,
  output logic [1:0]    res_n
);

  localparam int COL_W = $clog2(LINE_LENGTH);
  localparam int OW    = alx_pkg::COL_OUT_W;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_LENGTH - 1);

  logic [2:0]       mode_r, mode_nxt;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [COL_W-1:0] token_start_r, token_start_nxt;
  logic             radix_hex_r, radix_hex_nxt;

  logic [COL_W-1:0] col_bump;
  logic [OW-1:0]    col9, bump9, ts9;
  logic             radix_digit;

  // Restart from idle.
  logic [2:0]       st_mode;
  logic             st_ts_load, st_radix_load, st_radix_val, st_emit;
  alx_pkg::res_t    st_res;

  // Token closed by the current mode.
  logic             use_start, p_emit;
  alx_pkg::res_t    p_res;

  assign col_bump    = (column_r >= COL_MAX) ? COL_MAX : column_r + 1'b1;
  assign col9        = OW'(column_r);
  assign bump9       = OW'(col_bump);
  assign ts9         = OW'(token_start_r);
  assign radix_digit = alx_pkg::is_dec(ch) || (radix_hex_r && alx_pkg::is_hex_letter(ch));

  always_comb begin
    st_mode       = alx_pkg::MODE_IDLE;
    st_ts_load    = 1'b0;
    st_radix_load = 1'b0;
    st_radix_val  = 1'b0;
    st_emit       = 1'b0;
    st_res        = '0;
    if (ch == alx_pkg::CH_NUL) begin
      st_emit          = 1'b1;
      st_res.kind      = alx_pkg::KIND_EOL;
      st_res.start_col = col9;
      st_res.end_col   = col9;
    end else if (alx_pkg::is_blank(ch)) begin
      st_emit = 1'b0;
    end else if (ch == alx_pkg::CH_SEMI) begin
      st_mode    = alx_pkg::MODE_COMMENT;
      st_ts_load = 1'b1;
    end else if (ch == alx_pkg::CH_COLON || ch == alx_pkg::CH_COMMA) begin
      st_emit          = 1'b1;
      st_res.kind      = (ch == alx_pkg::CH_COLON) ? alx_pkg::KIND_COLON
                                                   : alx_pkg::KIND_COMMA;
      st_res.start_col = col9;
      st_res.end_col   = bump9;
    end else if (ch == alx_pkg::CH_DOLLAR || ch == alx_pkg::CH_HASH) begin
      st_mode       = alx_pkg::MODE_PREFIX;
      st_ts_load    = 1'b1;
      st_radix_load = 1'b1;
      st_radix_val  = (ch == alx_pkg::CH_DOLLAR);
    end else if (ch == alx_pkg::CH_QUOTE) begin
      st_mode    = alx_pkg::MODE_STRING;
      st_ts_load = 1'b1;
    end else if (alx_pkg::is_alpha(ch) || ch == alx_pkg::CH_UNDER || ch == alx_pkg::CH_DOT) begin
      st_mode    = alx_pkg::MODE_NAME;
      st_ts_load = 1'b1;
    end else begin
      st_emit           = 1'b1;
      st_res.kind       = alx_pkg::KIND_STRAY;
      st_res.start_col  = col9;
      st_res.end_col    = bump9;
      st_res.stray_char = ch;
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    token_start_nxt = token_start_r;
    radix_hex_nxt   = radix_hex_r;
    use_start       = 1'b0;
    p_emit          = 1'b0;
    p_res           = '0;
    p_res.start_col = ts9;
    p_res.end_col   = col9;

    unique case (mode_r) inside
      alx_pkg::MODE_IDLE: begin
        use_start = 1'b1;
      end
      alx_pkg::MODE_NAME: begin
        if (!(alx_pkg::is_alpha(ch) || alx_pkg::is_dec(ch) || ch == alx_pkg::CH_UNDER)) begin
          p_emit     = 1'b1;
          p_res.kind = alx_pkg::KIND_NAME;
          use_start  = 1'b1;
        end
      end
      alx_pkg::MODE_PREFIX, alx_pkg::MODE_MINUS: begin
        if (mode_r == alx_pkg::MODE_PREFIX && ch == alx_pkg::CH_MINUS) begin
          mode_nxt = alx_pkg::MODE_MINUS;
        end else if (radix_digit) begin
          mode_nxt = alx_pkg::MODE_DIGITS;
        end else begin
          p_emit       = 1'b1;
          p_res.kind   = alx_pkg::KIND_BADINT;
          p_res.is_hex = radix_hex_r;
          use_start    = 1'b1;
        end
      end
      alx_pkg::MODE_DIGITS: begin
        if (!radix_digit) begin
          p_emit       = 1'b1;
          p_res.kind   = alx_pkg::KIND_INT;
          p_res.is_hex = radix_hex_r;
          use_start    = 1'b1;
        end
      end
      alx_pkg::MODE_STRING, alx_pkg::MODE_STR_BS: begin
        if (ch == alx_pkg::CH_NUL) begin
          p_emit     = 1'b1;
          p_res.kind = alx_pkg::KIND_UNTERM;
          use_start  = 1'b1;
        end else if (ch == alx_pkg::CH_BSLASH) begin
          mode_nxt = alx_pkg::MODE_STR_BS;
        end else if (ch == alx_pkg::CH_QUOTE && mode_r == alx_pkg::MODE_STRING) begin
          p_emit        = 1'b1;
          p_res.kind    = alx_pkg::KIND_STRING;
          p_res.end_col = bump9;
          mode_nxt      = alx_pkg::MODE_IDLE;
        end else begin
          mode_nxt = alx_pkg::MODE_STRING;
        end
      end
      default: begin
        // Comment: runs to the end of the line.
        if (ch == alx_pkg::CH_NUL) begin
          p_emit     = 1'b1;
          p_res.kind = alx_pkg::KIND_EOL;
          mode_nxt   = alx_pkg::MODE_IDLE;
        end
      end
    endcase

    if (use_start) begin
      mode_nxt = st_mode;
      if (st_ts_load) begin
        token_start_nxt = column_r;
      end
      if (st_radix_load) begin
        radix_hex_nxt = st_radix_val;
      end
    end

    if (ch == alx_pkg::CH_NUL) begin
      mode_nxt        = alx_pkg::MODE_IDLE;
      column_nxt      = '0;
      token_start_nxt = '0;
      radix_hex_nxt   = 1'b0;
    end else begin
      column_nxt = col_bump;
    end
  end

  // Pack the emitted tokens into the two result slots.
  always_comb begin
    res0  = p_res;
    res1  = st_res;
    res_n = 2'd0;
    if (p_emit && use_start && st_emit) begin
      res_n = 2'd2;
    end else if (p_emit) begin
      res_n = 2'd1;
    end else if (use_start && st_emit) begin
      res0  = st_res;
      res_n = 2'd1;
    end
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= alx_pkg::MODE_IDLE;
      column_r      <= '0;
      token_start_r <= '0;
      radix_hex_r   <= 1'b0;
    end else if (step_en) begin
      mode_r        <= mode_nxt;
      column_r      <= column_nxt;
      token_start_r <= token_start_nxt;
      radix_hex_r   <= radix_hex_nxt;
    end
  end

endmodule

// ===== hw/rtl/alx_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module alx_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  alx_pkg::res_t push0,
  input  alx_pkg::res_t push1,
  input  logic          pop,
  output alx_pkg::res_t head,
  output logic          not_empty,
  output logic          room2
);

  localparam int PW = alx_pkg::FIFO_PTR_W;
  localparam int CW = alx_pkg::FIFO_CNT_W;

  alx_pkg::res_t   mem_r [alx_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign room2     = (count_r <= CW'(alx_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/assembly_line_lexer_core.sv =====
// ----------------------------------------------------------------------------
// Assembly line lexer core
// Lexes one character of an assembly source line per clock into tokens while in_stall is low.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_ch) carries one source byte per
// item; a zero byte ends the line. The result channel (out_valid, out_stall
// and the out_ fields) carries one token or error report per item. A byte
// that closes a pending token may also open or complete another one, so a
// single input item can cause zero, one or two result items; out_last marks
// the last result caused by a given input byte.
// The byte is registered at acceptance, then lexed and written into a
// four-entry result queue, whose head drives the output ports. Throughput
// is one input item per clock as long as the queue holds at most two
// results; the output side drains one result per clock while out_stall is
// low, so lines that produce two results for one byte briefly fill it.
// When the receiver stalls, the queue fills and in_stall rises; no result
// is lost or repeated. A synchronous reset (rst_n low) empties the queue,
// drops the held byte and returns the lexer to idle at column zero.
// ----------------------------------------------------------------------------
module assembly_line_lexer_core #(
  parameter int LINE_LENGTH = alx_pkg::LINE_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_ch,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_kind,
  output logic [alx_pkg::COL_OUT_W-1:0]  out_start_column,
  output logic [alx_pkg::COL_OUT_W-1:0]  out_end_column,
  output logic                           out_is_hex,
  output logic [7:0]                     out_stray_char,
  output logic                           out_last
);

  // Input register: holds one byte until the queue has room for the
  // worst case of two results.
  logic          hold_valid_r, hold_valid_nxt;
  logic [7:0]    hold_ch_r;
  logic          in_accept, advance, room2, not_empty, pop;
  logic [1:0]    res_n;
  alx_pkg::res_t res0, res1, head;

  assign advance   = hold_valid_r && room2;
  assign in_stall  = hold_valid_r && !room2;
  assign in_accept = in_valid && !in_stall;
  assign pop       = not_empty && !out_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_ch_r <= in_ch;
    end
  end

  // The lexer state only moves when the held byte is actually consumed.
  alx_step #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .ch      (hold_ch_r),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n)
  );

  alx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (advance ? res_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  assign out_valid        = not_empty;
  assign out_kind         = head.kind;
  assign out_start_column = head.start_col;
  assign out_end_column   = head.end_col;
  assign out_is_hex       = head.is_hex;
  assign out_stray_char   = head.stray_char;
  assign out_last         = head.last;

endmodule
